@@ hw/rtl/layer_normalization_core_macros.svh @@
// Assertion macros shared by the layer normalization RTL.
// Expects the including module to provide aclk and aresetn.
`ifndef LAYER_NORMALIZATION_CORE_MACROS_SVH
`define LAYER_NORMALIZATION_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LNC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define LNC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lnc_pkg.sv @@
// Package for the layer normalization core: payload structs, codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package lnc_pkg;

    localparam int MAX_LEN_DEF = 1024;

    // Shared divider: dividend up to 2^48, divisor up to 33 bits.
    localparam int DIV_W  = 49;
    localparam int DEN_W  = 33;
    localparam int REM_W  = 34;
    // Square root: radicand padded to an even width, root of 25 bits.
    localparam int RAD_W  = 50;
    localparam int ROOT_W = 25;
    localparam int SQR_W  = 27;

    localparam logic [15:0] EPS_RESET = 16'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_VECTOR = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] sample;
        logic signed [15:0] gain;
        logic signed [15:0] bias;
        logic               last;
    } lnc_in_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               final_res;
        logic [1:0]         error;
    } lnc_out_t;

endpackage

@@ hw/rtl/layer_normalization_core.sv @@
// Layer normalization core. A load request is taken in the idle state (plus result delivery
// when the sample is dropped). The load marked last starts the statistics sequencer, which
// uses one shared restoring divider for the mean, walks the sample memory once, divides for
// the variance and, unless variance plus epsilon is zero, divides for the reciprocal and runs
// a 25-step digit square root; no request is taken meanwhile. An emit request runs one memory
// read, two passes through the shared multiplier and one rounding step, then the result register.
// Depends on lnc_pkg and layer_normalization_core_macros.svh.
`timescale 1ns / 1ps

`include "layer_normalization_core_macros.svh"

module layer_normalization_core import lnc_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lnc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output lnc_out_t    m_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int SUM_W = 16 + CNT_W;
    localparam int SQ_W  = 32 + CNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV    = 4'd1;
    localparam logic [3:0] ST_WALK   = 4'd2;
    localparam logic [3:0] ST_SQRT   = 4'd3;
    localparam logic [3:0] ST_E_MUL1 = 4'd4;
    localparam logic [3:0] ST_E_MUL2 = 4'd5;
    localparam logic [3:0] ST_E_OUT  = 4'd6;
    localparam logic [3:0] ST_OUT    = 4'd7;

    localparam logic [1:0] PH_MEAN  = 2'd0;
    localparam logic [1:0] PH_VAR   = 2'd1;
    localparam logic [1:0] PH_RECIP = 2'd2;

    logic [3:0]              state_reg;
    logic [15:0]             eps_reg;
    logic [15:0]             eps_snap_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [15:0]      mean_reg;
    logic [ROOT_W-1:0]       scale_reg;
    logic [CNT_W-1:0]        emit_idx_reg;
    logic                    ready_vec_reg;
    lnc_out_t                pend_reg;
    logic                    pend_flag_reg;

    logic [1:0]              phase_reg;
    logic [DIV_W-1:0]        div_num_reg;
    logic [DEN_W-1:0]        div_den_reg;
    logic [REM_W-1:0]        div_rem_reg;
    logic [DIV_W-1:0]        div_quo_reg;
    logic [5:0]              div_cnt_reg;
    logic                    sum_neg_reg;

    logic [CNT_W-1:0]        walk_idx_reg;
    logic                    walk_v1_reg;
    logic                    walk_v2_reg;
    logic [SQ_W-1:0]         sumsq_reg;

    logic [RAD_W-1:0]        sq_rad_reg;
    logic [SQR_W-1:0]        sq_rem_reg;
    logic [ROOT_W-1:0]       sq_root_reg;
    logic [4:0]              sq_cnt_reg;

    logic signed [15:0]      gain_reg;
    logic signed [15:0]      bias_reg;
    logic signed [59:0]      prod_reg;
    logic [15:0]             rd_data_reg;
    logic                    m_valid_reg;
    lnc_out_t                m_data_reg;

    logic [15:0]             mem [MAX_LEN];

    logic                    accept;
    logic [CNT_W-1:0]        load_base;
    logic signed [SUM_W-1:0] sum_base;
    logic                    load_store;
    logic [CNT_W-1:0]        count_after;
    logic signed [SUM_W-1:0] sum_after;
    logic [SUM_W-1:0]        sum_mag;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [16:0]      diff;
    logic signed [33:0]      mul_a;
    logic signed [25:0]      mul_b;
    logic signed [59:0]      mul_p;
    logic [REM_W-1:0]        rem_sh;
    logic                    q_bit;
    logic [REM_W-1:0]        rem_new;
    logic [DIV_W-1:0]        quo_new;
    logic [15:0]             q16;
    logic [DEN_W-1:0]        v_sum;
    logic [SQR_W+1:0]        sq_sh;
    logic [SQR_W+1:0]        sq_trial;
    logic                    sq_ge;
    logic [SQR_W-1:0]        sq_rem_new;
    logic [ROOT_W-1:0]       sq_root_new;
    logic signed [59:0]      rnd;
    logic signed [36:0]      r_tot;
    logic signed [15:0]      r_sat;
    logic                    fin;
    logic                    emit_no_vec;
    logic                    out_no_vec;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A load after a finished vector starts a new one from empty.
    assign load_base   = ready_vec_reg ? '0 : count_reg;
    assign sum_base    = ready_vec_reg ? '0 : sum_reg;
    assign load_store  = (load_base < MAX_CNT);
    assign count_after = load_store ? load_base + CNT_W'(1) : load_base;
    assign sum_after   = load_store ? sum_base + SUM_W'(s_data.sample) : sum_base;
    assign sum_mag     = sum_after[SUM_W-1] ? SUM_W'(-sum_after) : SUM_W'(sum_after);

    assign rd_addr = (state_reg == ST_WALK) ? walk_idx_reg[IDX_W-1:0]
                                            : emit_idx_reg[IDX_W-1:0];
    assign diff = $signed({rd_data_reg[15], rd_data_reg}) - $signed({mean_reg[15], mean_reg});

    // Shared multiplier: d*d on the walk, d*gain and then that product times scale on emit.
    always_comb begin
        mul_a = 34'(diff);
        mul_b = $signed({1'b0, scale_reg});
        unique case (state_reg)
            ST_WALK:   mul_b = 26'(diff);
            ST_E_MUL1: mul_b = 26'(gain_reg);
            ST_E_MUL2: mul_a = prod_reg[33:0];
            default:   mul_a = 34'(diff);
        endcase
    end
    assign mul_p = 60'(mul_a) * 60'(mul_b);

    // One restoring division step per cycle.
    assign rem_sh  = {div_rem_reg[REM_W-2:0], div_num_reg[DIV_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, div_den_reg});
    assign rem_new = q_bit ? rem_sh - {1'b0, div_den_reg} : rem_sh;
    assign quo_new = {div_quo_reg[DIV_W-2:0], q_bit};
    assign q16     = quo_new[15:0];
    assign v_sum   = {1'b0, quo_new[31:0]} + DEN_W'(eps_snap_reg);

    // One digit of the square root per cycle, two radicand bits at a time.
    assign sq_sh       = {sq_rem_reg, sq_rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial    = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge       = (sq_sh >= sq_trial);
    assign sq_rem_new  = sq_ge ? SQR_W'(sq_sh - sq_trial) : SQR_W'(sq_sh);
    assign sq_root_new = {sq_root_reg[ROOT_W-2:0], sq_ge};

    // Round to nearest with ties up, add the bias, then saturate.
    assign rnd   = prod_reg + 60'sd8388608;
    assign r_tot = 37'($signed(rnd[59:24])) + 37'(bias_reg);
    always_comb begin
        if (r_tot > 37'sd32767) begin
            r_sat = 16'sh7FFF;
        end else if (r_tot < -37'sd32768) begin
            r_sat = -16'sh8000;
        end else begin
            r_sat = r_tot[15:0];
        end
    end
    assign fin = ((emit_idx_reg + CNT_W'(1)) == count_reg);

    always_ff @(posedge aclk) begin
        if (accept && s_data.operation == OP_LOAD && load_store) begin
            mem[load_base[IDX_W-1:0]] <= s_data.sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            eps_reg       <= EPS_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            scale_reg     <= '0;
            emit_idx_reg  <= '0;
            ready_vec_reg <= 1'b0;
            pend_flag_reg <= 1'b0;
            walk_v1_reg   <= 1'b0;
            walk_v2_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                eps_reg <= cfg_wdata;
            end
            // In ST_OUT the valid flag is either held or reloaded below.
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_data.operation == OP_LOAD) begin
                            ready_vec_reg <= 1'b0;
                            if (ready_vec_reg) begin
                                emit_idx_reg <= '0;
                            end
                            count_reg     <= count_after;
                            sum_reg       <= sum_after;
                            pend_reg      <= '{value: '0, final_res: 1'b0, error: ERR_OVERFLOW};
                            pend_flag_reg <= !load_store;
                            if (s_data.last) begin
                                eps_snap_reg <= eps_reg;
                                sum_neg_reg  <= sum_after[SUM_W-1];
                                div_num_reg  <= DIV_W'(sum_mag);
                                div_den_reg  <= DEN_W'(count_after);
                                div_rem_reg  <= '0;
                                div_quo_reg  <= '0;
                                div_cnt_reg  <= 6'(DIV_W - 1);
                                phase_reg    <= PH_MEAN;
                                state_reg    <= ST_DIV;
                            end else if (!load_store) begin
                                state_reg <= ST_OUT;
                            end
                        end else begin
                            gain_reg <= s_data.gain;
                            bias_reg <= s_data.bias;
                            if (!ready_vec_reg) begin
                                pend_reg  <= '{value: '0, final_res: 1'b0, error: ERR_NO_VECTOR};
                                state_reg <= ST_OUT;
                            end else begin
                                state_reg <= ST_E_MUL1;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (div_cnt_reg != '0) begin
                        div_num_reg <= {div_num_reg[DIV_W-2:0], 1'b0};
                        div_rem_reg <= rem_new;
                        div_quo_reg <= quo_new;
                        div_cnt_reg <= div_cnt_reg - 6'd1;
                    end else begin
                        unique case (phase_reg)
                            PH_MEAN: begin
                                mean_reg     <= sum_neg_reg ? -$signed(q16) : $signed(q16);
                                walk_idx_reg <= '0;
                                walk_v1_reg  <= 1'b0;
                                walk_v2_reg  <= 1'b0;
                                sumsq_reg    <= '0;
                                state_reg    <= ST_WALK;
                            end
                            PH_VAR: begin
                                if (v_sum == '0) begin
                                    scale_reg     <= ROOT_W'(1) << 24;
                                    ready_vec_reg <= 1'b1;
                                    emit_idx_reg  <= '0;
                                    state_reg     <= pend_flag_reg ? ST_OUT : ST_IDLE;
                                end else begin
                                    div_num_reg <= DIV_W'(1) << 48;
                                    div_den_reg <= v_sum;
                                    div_rem_reg <= '0;
                                    div_quo_reg <= '0;
                                    div_cnt_reg <= 6'(DIV_W - 1);
                                    phase_reg   <= PH_RECIP;
                                end
                            end
                            PH_RECIP: begin
                                sq_rad_reg  <= {1'b0, quo_new};
                                sq_rem_reg  <= '0;
                                sq_root_reg <= '0;
                                sq_cnt_reg  <= 5'(ROOT_W - 1);
                                state_reg   <= ST_SQRT;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_WALK: begin
                    // Address, read, square and accumulate overlap across elements.
                    walk_v1_reg <= (walk_idx_reg < count_reg);
                    if (walk_idx_reg < count_reg) begin
                        walk_idx_reg <= walk_idx_reg + CNT_W'(1);
                    end
                    walk_v2_reg <= walk_v1_reg;
                    if (walk_v1_reg) begin
                        prod_reg <= mul_p;
                    end
                    if (walk_v2_reg) begin
                        sumsq_reg <= sumsq_reg + SQ_W'(prod_reg[31:0]);
                    end
                    if (walk_idx_reg == count_reg && !walk_v1_reg && !walk_v2_reg) begin
                        div_num_reg <= DIV_W'(sumsq_reg);
                        div_den_reg <= DEN_W'(count_reg);
                        div_rem_reg <= '0;
                        div_quo_reg <= '0;
                        div_cnt_reg <= 6'(DIV_W - 1);
                        phase_reg   <= PH_VAR;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_SQRT: begin
                    sq_rad_reg  <= {sq_rad_reg[RAD_W-3:0], 2'b00};
                    sq_rem_reg  <= sq_rem_new;
                    sq_root_reg <= sq_root_new;
                    sq_cnt_reg  <= sq_cnt_reg - 5'd1;
                    if (sq_cnt_reg == '0) begin
                        scale_reg     <= sq_root_new;
                        ready_vec_reg <= 1'b1;
                        emit_idx_reg  <= '0;
                        state_reg     <= pend_flag_reg ? ST_OUT : ST_IDLE;
                    end
                end
                ST_E_MUL1: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_E_MUL2;
                end
                ST_E_MUL2: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_E_OUT;
                end
                ST_E_OUT: begin
                    pend_reg <= '{value: r_sat, final_res: fin, error: ERR_NONE};
                    if (fin) begin
                        ready_vec_reg <= 1'b0;
                        count_reg     <= '0;
                        sum_reg       <= '0;
                        emit_idx_reg  <= '0;
                    end else begin
                        emit_idx_reg <= emit_idx_reg + CNT_W'(1);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_data_reg    <= pend_reg;
                        pend_flag_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign emit_no_vec = accept && (s_data.operation == OP_EMIT) && !ready_vec_reg;
    assign out_no_vec  = (state_reg == ST_OUT) && (pend_reg.error == ERR_NO_VECTOR);

    `LNC_ASSERT(a_ready_nonempty, ready_vec_reg |-> (count_reg != '0), "ready vector is empty")
    `LNC_ASSERT(a_emit_in_range, ready_vec_reg |-> (emit_idx_reg < count_reg), "emit past end")
    `LNC_ASSERT(a_count_bound, count_reg <= MAX_CNT, "element count above capacity")
    `LNC_ASSERT_NEXT(a_no_vector, emit_no_vec, out_no_vec, "emit without vector not flagged")

endmodule
